[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ppm_pkg.sv]
`timescale 1ns / 1ps

package ppm_pkg;

	localparam int MAX_VERT = 4;
	localparam int IDX_W    = $clog2(MAX_VERT);
	localparam int CNT_W    = $clog2(MAX_VERT + 1);
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int CFG_IDX_W = 3;

	localparam int ACC_W  = 72;
	localparam int MA_W   = 36;
	localparam int MB_W   = 34;
	localparam int PROD_W = MA_W + MB_W;
	localparam int QP_W   = 34;

	localparam logic [1:0] ST_MESH = 2'd0;
	localparam logic [1:0] ST_WIND = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SZ     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RX     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RY     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RZ     = 3'd7;

	localparam logic [1:0] DST_NONE = 2'd0;
	localparam logic [1:0] DST_QP   = 2'd1;
	localparam logic [1:0] DST_POS  = 2'd2;
	localparam logic [1:0] DST_NRM  = 2'd3;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [63:0] norm_x;
		logic signed [63:0] norm_y;
		logic signed [63:0] norm_z;
		logic [1:0]         status;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic signed [31:0] prism_height;
		logic signed [31:0] shift_x;
		logic signed [31:0] shift_y;
		logic signed [31:0] shift_z;
		logic signed [31:0] rot_w;
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]             n;
		logic                         ovf;
		logic [MAX_VERT-1:0][31:0]    xs;
		logic [MAX_VERT-1:0][31:0]    ys;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[sv/polygon_prism_mesher.sv]
`timescale 1ns / 1ps

// channel   | handshake              | payload
// ----------+------------------------+-------------------
// vertex in | start, busy            | req (vertex_t)
// result    | res_valid (strobe)     | res (result_t)
// config    | cfg_we                 | cfg_idx, cfg_data
//
// A vertex is taken on start while busy is low; busy rises only while both queue slots hold polygons.
// The back end works one n-vertex polygon at a time, popping the next in idle, with one shared
// 36x34 multiplier (two-stage multiply/accumulate) that builds sum, quat terms, positions, normals.
// Mesh results leave in bursts of one per cycle from an output register; no stall possible.
// arst_n clears control state and loads the register reset values; no clearing pass.

module polygon_prism_mesher import ppm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  vertex_t              req,
	output logic                 res_valid,
	output result_t              res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_data
);

	cfg_t    cfg_q;
	job_t    push_job, pop_job;
	logic    push, pop;
	q_stat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{prism_height: '0, shift_x: '0, shift_y: '0, shift_z: '0,
				rot_w: 32'sh4000_0000, rot_x: '0, rot_y: '0, rot_z: '0};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HEIGHT: cfg_q.prism_height <= cfg_data;
				REG_SX:     cfg_q.shift_x      <= cfg_data;
				REG_SY:     cfg_q.shift_y      <= cfg_data;
				REG_SZ:     cfg_q.shift_z      <= cfg_data;
				REG_RW:     cfg_q.rot_w        <= cfg_data;
				REG_RX:     cfg_q.rot_x        <= cfg_data;
				REG_RY:     cfg_q.rot_y        <= cfg_data;
				REG_RZ:     cfg_q.rot_z        <= cfg_data;
				default: ;
			endcase
		end
	end

	ppm_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.qstat (qstat),
		.push  (push),
		.job   (push_job)
	);

	ppm_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (push_job),
		.pop   (pop),
		.rdata (pop_job),
		.qstat (qstat)
	);

	ppm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job      (pop_job),
		.qstat    (qstat),
		.pop      (pop),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

[sv/ppm_front.sv]
`timescale 1ns / 1ps

module ppm_front import ppm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  vertex_t req,
	input  q_stat_t qstat,
	output logic    push,
	output job_t    job
);

	logic [31:0]      store_x_q [MAX_VERT];
	logic [31:0]      store_y_q [MAX_VERT];
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             acc;
	logic             room;

	assign busy = qstat.full;
	assign acc  = start & ~busy;
	assign room = cnt_q < CNT_W'(MAX_VERT);
	assign push = acc & req.last_vertex;

	always_ff @(posedge clk) begin
		if (acc && room) begin
			store_x_q[cnt_q[IDX_W-1:0]] <= req.vertex_x;
			store_y_q[cnt_q[IDX_W-1:0]] <= req.vertex_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (req.last_vertex) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_comb begin
		job.n   = room ? cnt_q + CNT_W'(1) : cnt_q;
		job.ovf = ovf_q | ~room;
		for (int k = 0; k < MAX_VERT; k++) begin
			if (room && cnt_q[IDX_W-1:0] == IDX_W'(k)) begin
				job.xs[k] = req.vertex_x;
				job.ys[k] = req.vertex_y;
			end else begin
				job.xs[k] = store_x_q[k];
				job.ys[k] = store_y_q[k];
			end
		end
	end

endmodule

[sv/ppm_queue.sv]
`timescale 1ns / 1ps

module ppm_queue import ppm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    wdata,
	input  logic    pop,
	output job_t    rdata,
	output q_stat_t qstat
);

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign qstat.empty = cnt_q == '0;
	assign rdata       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == QPTR_W'(QDEPTH-1)) ? '0 : wr_q + QPTR_W'(1);
			if (pop)  rd_q <= (rd_q == QPTR_W'(QDEPTH-1)) ? '0 : rd_q + QPTR_W'(1);
			if (push && !pop)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

[sv/ppm_back.sv]
`timescale 1ns / 1ps

module ppm_back import ppm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  job_t    job,
	input  q_stat_t qstat,
	output logic    pop,
	output logic    res_valid,
	output result_t res
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_SUM  = 4'd2;
	localparam logic [3:0] S_SUMD = 4'd3;
	localparam logic [3:0] S_QP   = 4'd4;
	localparam logic [3:0] S_MAT  = 4'd5;
	localparam logic [3:0] S_POS  = 4'd6;
	localparam logic [3:0] S_XL0  = 4'd7;
	localparam logic [3:0] S_XL1  = 4'd8;
	localparam logic [3:0] S_XL2  = 4'd9;
	localparam logic [3:0] S_XM   = 4'd10;
	localparam logic [3:0] S_XD   = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;
	localparam logic [3:0] S_STAT = 4'd13;
	localparam logic [3:0] S_WAIT = 4'd14;

	localparam logic [ACC_W-1:0] RND_QP  = ACC_W'(64'd1 << 29);
	localparam logic [ACC_W-1:0] RND_POS = ACC_W'(64'd1 << 30);
	localparam logic signed [MA_W-1:0] ONE_Q30 = MA_W'(64'd1 << 30);

	typedef logic [2:0][31:0] point_t;

	typedef struct packed {
		logic             vld;
		logic             clr;
		logic             neg;
		logic [1:0]       kind;
		logic             f;
		logic [IDX_W-1:0] v;
		logic [3:0]       c;
	} op_t;

	function automatic logic [63:0] sat64(input logic [ACC_W-1:0] v);
		logic [63:0] r;
		if (v[ACC_W-1:63] == {(ACC_W-63){v[63]}}) r = v[63:0];
		else if (v[ACC_W-1]) r = {1'b1, 63'd0};
		else r = {1'b0, {63{1'b1}}};
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic [ACC_W-1:0] v);
		logic [31:0] r;
		if (v[ACC_W-1:62] == {(ACC_W-62){v[62]}}) r = v[62:31];
		else if (v[ACC_W-1]) r = {1'b1, 31'd0};
		else r = {1'b0, {31{1'b1}}};
		return r;
	endfunction

	logic [3:0]       state_q, ret_q;
	logic [CNT_W-1:0] n_q, i_q, ip1, jn, im1;
	logic             ovf_q;
	logic [3:0]       k_q;
	logic [1:0]       r_q, c_q, grp_q, stat_q;
	logic [2:0]       e_q;
	logic             f_q, xtop_q;

	logic [MAX_VERT-1:0][31:0] x_q, y_q;
	logic signed [32:0] dx_q [MAX_VERT];
	logic signed [32:0] dy_q [MAX_VERT];
	logic signed [QP_W-1:0] qp_q [9];
	logic signed [MA_W-1:0] m_q  [9];
	logic signed [MA_W-1:0] qe   [9];
	point_t pos_q [2][MAX_VERT];
	point_t c0_q, rd_pt;
	logic signed [32:0] a_q [3];
	logic signed [32:0] b_q [3];
	logic [63:0] ntop_q [3];
	logic [63:0] nbot_q [3];
	logic [63:0] nside_q [3];

	op_t iss, op_s1, op_s2;
	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic [ACC_W-1:0]         iss_base, base_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q, acc_next, acc_sel, addend;
	logic                     pipe_busy;

	logic             rd_f;
	logic [IDX_W-1:0] rd_v;
	logic [IDX_W-1:0] iv, jv;
	logic [3:0]       mi;
	logic signed [31:0] qa, qb, shf;
	logic signed [MB_W-1:0] hh;
	logic             emit_last;

	result_t res_q;
	logic    res_valid_q;

	assign ip1 = i_q + CNT_W'(1);
	assign im1 = i_q - CNT_W'(1);
	assign jn  = (ip1 == n_q) ? '0 : ip1;
	assign iv  = i_q[IDX_W-1:0];
	assign jv  = jn[IDX_W-1:0];
	assign pop = (state_q == S_IDLE) && !qstat.empty;
	assign pipe_busy = op_s1.vld | op_s2.vld;
	assign res = res_q;
	assign res_valid = res_valid_q;

	// operand issue to the shared multiplier
	always_comb begin
		iss      = '0;
		mul_a    = '0;
		mul_b    = '0;
		iss_base = '0;
		qa       = '0;
		qb       = '0;
		shf      = '0;
		mi       = 4'(r_q) * 4'd3 + 4'(c_q);
		hh       = MB_W'($signed(cfg.prism_height));
		case (k_q)
			4'd0: begin qa = cfg.rot_x; qb = cfg.rot_x; end
			4'd1: begin qa = cfg.rot_y; qb = cfg.rot_y; end
			4'd2: begin qa = cfg.rot_z; qb = cfg.rot_z; end
			4'd3: begin qa = cfg.rot_x; qb = cfg.rot_y; end
			4'd4: begin qa = cfg.rot_x; qb = cfg.rot_z; end
			4'd5: begin qa = cfg.rot_y; qb = cfg.rot_z; end
			4'd6: begin qa = cfg.rot_x; qb = cfg.rot_w; end
			4'd7: begin qa = cfg.rot_y; qb = cfg.rot_w; end
			default: begin qa = cfg.rot_z; qb = cfg.rot_w; end
		endcase
		case (r_q)
			2'd0: shf = cfg.shift_x;
			2'd1: shf = cfg.shift_y;
			default: shf = cfg.shift_z;
		endcase
		case (state_q)
			S_SUM: begin
				iss.vld = 1'b1;
				iss.clr = (i_q == '0) && !k_q[0];
				iss.neg = k_q[0];
				mul_a   = k_q[0] ? MA_W'(dy_q[iv]) : MA_W'(dx_q[iv]);
				mul_b   = k_q[0] ? MB_W'(dx_q[jv]) : MB_W'(dy_q[jv]);
			end
			S_QP: begin
				iss.vld  = 1'b1;
				iss.clr  = 1'b1;
				iss.kind = DST_QP;
				iss.c    = k_q;
				mul_a    = MA_W'(qa);
				mul_b    = MB_W'(qb);
				iss_base = RND_QP;
			end
			S_POS: begin
				iss.vld  = 1'b1;
				iss.clr  = (c_q == 2'd0);
				iss.kind = (c_q == 2'd2) ? DST_POS : DST_NONE;
				iss.f    = f_q;
				iss.v    = iv;
				iss.c    = 4'(r_q);
				mul_a    = m_q[mi];
				case (c_q)
					2'd0: mul_b = MB_W'($signed({x_q[iv], 1'b0}));
					2'd1: mul_b = MB_W'($signed({y_q[iv], 1'b0}));
					default: mul_b = f_q ? -hh : hh;
				endcase
				iss_base = (ACC_W'(shf) << 31) + RND_POS;
			end
			S_XM: begin
				iss.vld  = 1'b1;
				iss.clr  = !k_q[0];
				iss.neg  = k_q[0];
				iss.kind = k_q[0] ? DST_NRM : DST_NONE;
				iss.c    = {2'd0, k_q[2:1]};
				case (k_q)
					4'd0: begin mul_a = MA_W'(a_q[1]); mul_b = MB_W'(b_q[2]); end
					4'd1: begin mul_a = MA_W'(a_q[2]); mul_b = MB_W'(b_q[1]); end
					4'd2: begin mul_a = MA_W'(a_q[2]); mul_b = MB_W'(b_q[0]); end
					4'd3: begin mul_a = MA_W'(a_q[0]); mul_b = MB_W'(b_q[2]); end
					4'd4: begin mul_a = MA_W'(a_q[0]); mul_b = MB_W'(b_q[1]); end
					default: begin mul_a = MA_W'(a_q[1]); mul_b = MB_W'(b_q[0]); end
				endcase
			end
			default: ;
		endcase
	end

	assign acc_sel  = op_s1.clr ? $signed(base_s1) : acc_q;
	assign addend   = ACC_W'(prod_s1);
	assign acc_next = op_s1.neg ? acc_sel - addend : acc_sel + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
		end else begin
			op_s1 <= iss;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		base_s1 <= iss_base;
		if (op_s1.vld) acc_q <= acc_next;
		if (op_s2.vld) begin
			case (op_s2.kind)
				DST_QP:  qp_q[op_s2.c] <= acc_q[63:30];
				DST_POS: pos_q[op_s2.f][op_s2.v][op_s2.c[1:0]] <= sat32(acc_q);
				DST_NRM: begin
					if (xtop_q) begin
						ntop_q[op_s2.c[1:0]] <= sat64(acc_q);
						nbot_q[op_s2.c[1:0]] <= sat64(-acc_q);
					end else begin
						nside_q[op_s2.c[1:0]] <= sat64(acc_q);
					end
				end
				default: ;
			endcase
		end
	end

	// point read port: cross loads and emission
	always_comb begin
		rd_f = 1'b0;
		rd_v = '0;
		case (state_q)
			S_XL0: begin rd_f = 1'b0; rd_v = xtop_q ? '0 : iv; end
			S_XL1: begin rd_f = !xtop_q; rd_v = xtop_q ? IDX_W'(1) : iv; end
			S_XL2: begin rd_f = !xtop_q; rd_v = xtop_q ? IDX_W'(2) : jv; end
			default: begin
				case (grp_q)
					2'd0: begin
						case (e_q)
							3'd0: rd_v = '0;
							3'd1: rd_v = im1[IDX_W-1:0];
							default: rd_v = iv;
						endcase
					end
					2'd1: begin
						case (e_q)
							3'd0: begin rd_f = 1'b0; rd_v = iv; end
							3'd1: begin rd_f = 1'b1; rd_v = iv; end
							3'd2: begin rd_f = 1'b1; rd_v = jv; end
							3'd3: begin rd_f = 1'b0; rd_v = iv; end
							3'd4: begin rd_f = 1'b1; rd_v = jv; end
							default: begin rd_f = 1'b0; rd_v = jv; end
						endcase
					end
					default: begin
						rd_f = 1'b1;
						case (e_q)
							3'd0: rd_v = '0;
							3'd1: rd_v = iv;
							default: rd_v = im1[IDX_W-1:0];
						endcase
					end
				endcase
			end
		endcase
	end

	assign rd_pt     = pos_q[rd_f][rd_v];
	assign emit_last = (grp_q == 2'd2) && (e_q == 3'd2) && (ip1 == n_q);

	always_comb begin
		for (int k = 0; k < 9; k++) qe[k] = MA_W'(qp_q[k]);
	end

	// payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q   <= job.n;
				ovf_q <= job.ovf;
				x_q   <= job.xs;
				y_q   <= job.ys;
			end
			S_PREP: begin
				for (int k = 0; k < MAX_VERT; k++) begin
					dx_q[k] <= 33'($signed(x_q[k])) - 33'($signed(x_q[0]));
					dy_q[k] <= 33'($signed(y_q[k])) - 33'($signed(y_q[0]));
				end
			end
			S_MAT: begin
				m_q[0] <= ONE_Q30 - ((qe[1] + qe[2]) <<< 1);
				m_q[1] <= (qe[3] - qe[8]) <<< 1;
				m_q[2] <= (qe[4] + qe[7]) <<< 1;
				m_q[3] <= (qe[3] + qe[8]) <<< 1;
				m_q[4] <= ONE_Q30 - ((qe[0] + qe[2]) <<< 1);
				m_q[5] <= (qe[5] - qe[6]) <<< 1;
				m_q[6] <= (qe[4] - qe[7]) <<< 1;
				m_q[7] <= (qe[5] + qe[6]) <<< 1;
				m_q[8] <= ONE_Q30 - ((qe[0] + qe[1]) <<< 1);
			end
			S_XL0: c0_q <= rd_pt;
			S_XL1: begin
				for (int k = 0; k < 3; k++)
					b_q[k] <= 33'($signed(rd_pt[k])) - 33'($signed(c0_q[k]));
			end
			S_XL2: begin
				for (int k = 0; k < 3; k++)
					a_q[k] <= 33'($signed(rd_pt[k])) - 33'($signed(c0_q[k]));
			end
			default: ;
		endcase
		if (state_q == S_EMIT) begin
			res_q.pos_x  <= rd_pt[0];
			res_q.pos_y  <= rd_pt[1];
			res_q.pos_z  <= rd_pt[2];
			res_q.status <= ST_MESH;
			res_q.last_result <= emit_last;
			case (grp_q)
				2'd0: begin
					res_q.norm_x <= ntop_q[0];
					res_q.norm_y <= ntop_q[1];
					res_q.norm_z <= ntop_q[2];
				end
				2'd1: begin
					res_q.norm_x <= nside_q[0];
					res_q.norm_y <= nside_q[1];
					res_q.norm_z <= nside_q[2];
				end
				default: begin
					res_q.norm_x <= nbot_q[0];
					res_q.norm_y <= nbot_q[1];
					res_q.norm_z <= nbot_q[2];
				end
			endcase
		end else if (state_q == S_STAT) begin
			res_q <= '{pos_x: '0, pos_y: '0, pos_z: '0, norm_x: '0, norm_y: '0,
				norm_z: '0, status: stat_q, last_result: 1'b1};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			i_q         <= '0;
			k_q         <= '0;
			r_q         <= '0;
			c_q         <= '0;
			f_q         <= 1'b0;
			e_q         <= '0;
			grp_q       <= '0;
			xtop_q      <= 1'b0;
			stat_q      <= ST_MESH;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == S_EMIT) || (state_q == S_STAT);
			case (state_q)
				S_IDLE: if (!qstat.empty) state_q <= S_PREP;
				S_PREP: begin
					i_q <= '0;
					k_q <= '0;
					if (ovf_q) begin
						stat_q  <= ST_OVF;
						state_q <= S_STAT;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					k_q <= {3'd0, !k_q[0]};
					if (k_q[0]) begin
						if (ip1 == n_q) begin
							ret_q   <= S_SUMD;
							state_q <= S_WAIT;
						end else begin
							i_q <= ip1;
						end
					end
				end
				S_SUMD: begin
					k_q <= '0;
					if (n_q < CNT_W'(3) || !acc_q[ACC_W-1]) begin
						stat_q  <= ST_WIND;
						state_q <= S_STAT;
					end else begin
						state_q <= S_QP;
					end
				end
				S_QP: begin
					if (k_q == 4'd8) begin
						ret_q   <= S_MAT;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_MAT: begin
					i_q     <= '0;
					f_q     <= 1'b0;
					r_q     <= '0;
					c_q     <= '0;
					state_q <= S_POS;
				end
				S_POS: begin
					if (c_q == 2'd2) begin
						c_q <= '0;
						if (r_q == 2'd2) begin
							r_q <= '0;
							f_q <= !f_q;
							if (f_q) begin
								if (ip1 == n_q) begin
									xtop_q  <= 1'b1;
									ret_q   <= S_XL0;
									state_q <= S_WAIT;
								end else begin
									i_q <= ip1;
								end
							end
						end else begin
							r_q <= r_q + 2'd1;
						end
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
				S_XL0: state_q <= S_XL1;
				S_XL1: state_q <= S_XL2;
				S_XL2: begin
					k_q     <= '0;
					state_q <= S_XM;
				end
				S_XM: begin
					if (k_q == 4'd5) begin
						ret_q   <= S_XD;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_XD: begin
					e_q     <= '0;
					state_q <= S_EMIT;
					if (xtop_q) begin
						xtop_q <= 1'b0;
						grp_q  <= 2'd0;
						i_q    <= CNT_W'(2);
					end
				end
				S_EMIT: begin
					case (grp_q)
						2'd0: begin
							if (e_q == 3'd2) begin
								e_q <= '0;
								if (ip1 == n_q) begin
									grp_q   <= 2'd1;
									i_q     <= '0;
									state_q <= S_XL0;
								end else begin
									i_q <= ip1;
								end
							end else begin
								e_q <= e_q + 3'd1;
							end
						end
						2'd1: begin
							if (e_q == 3'd5) begin
								e_q <= '0;
								if (ip1 == n_q) begin
									grp_q <= 2'd2;
									i_q   <= CNT_W'(2);
								end else begin
									i_q     <= ip1;
									state_q <= S_XL0;
								end
							end else begin
								e_q <= e_q + 3'd1;
							end
						end
						default: begin
							if (e_q == 3'd2) begin
								e_q <= '0;
								if (ip1 == n_q) state_q <= S_IDLE;
								else i_q <= ip1;
							end else begin
								e_q <= e_q + 3'd1;
							end
						end
					endcase
				end
				S_STAT: state_q <= S_IDLE;
				S_WAIT: if (!pipe_busy) state_q <= ret_q;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[sv/ppm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppm_assert import ppm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input vertex_t              req,
	input logic                 res_valid,
	input result_t              res,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [31:0]          cfg_data
);

	`AST_IMP(a_stat_last, res_valid && res.status != ST_MESH, res.last_result, "status not last")
	`AST_IMP(a_stat_zero, res_valid && res.status != ST_MESH, res.pos_x == 0, "status with data")
	`AST_NXT(a_gap_after_last, res_valid && res.last_result, !res_valid, "result after end")

endmodule

bind polygon_prism_mesher ppm_assert u_chk (.*);
